@@ sv/mvm_pkg.sv @@
package mvm_pkg;

  // Port field widths
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int ELEM_W  = 32;
  localparam int ACC_W   = 64;
  localparam int CNT_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Index and count limit set by the six-bit index fields
  localparam int INDEX_LIMIT = 64;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE_MATRIX = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_VECTOR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE      = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // One memory read issued by the sequencer
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first_col;
    logic             last_col;
    logic             last_row;
  } seq_issue_t;

  // Tag that follows a read through the pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic             first_col;
    logic             last_col;
    logic             last_row;
  } pipe_meta_t;

  // Load write into the stores
  typedef struct packed {
    logic              mat_we;
    logic              vec_we;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] data;
  } mem_write_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } result_t;

endpackage

@@ sv/mvm_ifs.sv @@
interface mvm_in_if;
  import mvm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         column_index;
  logic signed [ELEM_W-1:0] element_value;
  modport source(output valid, command, row_index, column_index, element_value,
                 input ready);
  modport sink(input valid, command, row_index, column_index, element_value,
               output ready);
endinterface

interface mvm_out_if;
  import mvm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        result_row;
  logic signed [ACC_W-1:0] product_value;
  logic                    last_row;
  modport source(output valid, result_row, product_value, last_row, input ready);
  modport sink(input valid, result_row, product_value, last_row, output ready);
endinterface

interface mvm_cfg_if;
  import mvm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ sv/mvm_seq.sv @@
module mvm_seq #(
  parameter int MAX_DIM = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     adv,
  input  logic [mvm_pkg::CNT_W-1:0] row_count,
  input  logic [mvm_pkg::CNT_W-1:0] column_count,
  output logic                     idle,
  output mvm_pkg::seq_issue_t      issue
);
  import mvm_pkg::*;

  localparam int EFF_DIM = (MAX_DIM < INDEX_LIMIT) ? MAX_DIM : INDEX_LIMIT;
  localparam int IW      = $clog2(EFF_DIM);

  seq_state_t    state_r, state_nxt;
  logic [IW-1:0] row_r, col_r;
  logic [IW-1:0] rows_m1_r, cols_m1_r;
  logic [IW-1:0] rows_m1, cols_m1;
  logic          last_col, last_row;

  // Clamp a count to 1..EFF_DIM, minus one
  always_comb begin
    priority if (row_count == '0) begin
      rows_m1 = '0;
    end else if (row_count > CNT_W'(EFF_DIM)) begin
      rows_m1 = IW'(EFF_DIM - 1);
    end else begin
      rows_m1 = IW'(row_count - CNT_W'(1));
    end
    priority if (column_count == '0) begin
      cols_m1 = '0;
    end else if (column_count > CNT_W'(EFF_DIM)) begin
      cols_m1 = IW'(EFF_DIM - 1);
    end else begin
      cols_m1 = IW'(column_count - CNT_W'(1));
    end
  end

  assign last_col = (col_r == cols_m1_r);
  assign last_row = (row_r == rows_m1_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) state_nxt = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (adv && last_col && last_row) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    idle            = (state_r == SEQ_IDLE);
    issue.valid     = (state_r == SEQ_RUN);
    issue.row       = IDX_W'(row_r);
    issue.col       = IDX_W'(col_r);
    issue.first_col = (col_r == '0);
    issue.last_col  = last_col;
    issue.last_row  = last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SEQ_IDLE;
      row_r     <= '0;
      col_r     <= '0;
      rows_m1_r <= '0;
      cols_m1_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (start && state_r == SEQ_IDLE) begin
        row_r     <= '0;
        col_r     <= '0;
        rows_m1_r <= rows_m1;
        cols_m1_r <= cols_m1;
      end else if (state_r == SEQ_RUN && adv) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= row_r + IW'(1);
        end else begin
          col_r <= col_r + IW'(1);
        end
      end
    end
  end

endmodule

@@ sv/mvm_mem.sv @@
module mvm_mem #(
  parameter int MAX_DIM     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  mvm_pkg::seq_issue_t     issue,
  input  mvm_pkg::mem_write_t     wr,
  output logic [VALUE_WIDTH-1:0]  mat_q,
  output logic [VALUE_WIDTH-1:0]  vec_q,
  output mvm_pkg::pipe_meta_t     meta
);
  import mvm_pkg::*;

  localparam int EFF_DIM   = (MAX_DIM < INDEX_LIMIT) ? MAX_DIM : INDEX_LIMIT;
  localparam int IW        = $clog2(EFF_DIM);
  localparam int MAT_DEPTH = 1 << (2 * IW);
  localparam int VEC_DEPTH = 1 << IW;

  logic [VALUE_WIDTH-1:0] mat_mem [MAT_DEPTH];
  logic [VALUE_WIDTH-1:0] vec_mem [VEC_DEPTH];
  logic [VALUE_WIDTH-1:0] mat_q_r, vec_q_r;
  pipe_meta_t             meta_r;
  logic [2*IW-1:0]        mat_waddr, mat_raddr;

  assign mat_waddr = {wr.row[IW-1:0], wr.col[IW-1:0]};
  assign mat_raddr = {issue.row[IW-1:0], issue.col[IW-1:0]};

  // Write port: loads only
  always_ff @(posedge clk) begin
    if (wr.mat_we) mat_mem[mat_waddr] <= wr.data[VALUE_WIDTH-1:0];
    if (wr.vec_we) vec_mem[wr.col[IW-1:0]] <= wr.data[VALUE_WIDTH-1:0];
  end

  // Read port: hold data while the pipeline stalls
  always_ff @(posedge clk) begin
    if (adv && issue.valid) begin
      mat_q_r <= mat_mem[mat_raddr];
      vec_q_r <= vec_mem[issue.col[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else if (adv) begin
      meta_r.valid <= issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r.row       <= issue.row;
      meta_r.first_col <= issue.first_col;
      meta_r.last_col  <= issue.last_col;
      meta_r.last_row  <= issue.last_row;
    end
  end

  assign mat_q = mat_q_r;
  assign vec_q = vec_q_r;
  assign meta  = meta_r;

endmodule

@@ sv/mvm_mac.sv @@
module mvm_mac #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [VALUE_WIDTH-1:0] mat_q,
  input  logic [VALUE_WIDTH-1:0] vec_q,
  input  mvm_pkg::pipe_meta_t    meta_in,
  input  logic                   out_ready,
  output logic                   adv,
  output logic                   out_valid,
  output mvm_pkg::result_t       result
);
  import mvm_pkg::*;

  localparam int PROD_W = 2 * VALUE_WIDTH;

  logic signed [PROD_W-1:0] prod_full;
  logic signed [ACC_W-1:0]  prod_r;
  pipe_meta_t               meta_r;
  logic signed [ACC_W-1:0]  acc_r, acc_base, acc_sum, acc_nxt;
  logic                     ovf;
  logic                     out_valid_r;
  result_t                  result_r;

  // Advance the whole pipeline unless a result waits
  assign adv = !out_valid_r || out_ready;

  assign prod_full = $signed(mat_q) * $signed(vec_q);

  // Saturating accumulate; a row's first term starts from zero
  always_comb begin
    acc_base = meta_r.first_col ? '0 : acc_r;
    acc_sum  = acc_base + prod_r;
    ovf      = (acc_base[ACC_W-1] == prod_r[ACC_W-1]) &&
               (acc_sum[ACC_W-1] != acc_base[ACC_W-1]);
    if (ovf) begin
      acc_nxt = acc_base[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (adv) begin
      meta_r.valid <= meta_in.valid;
      out_valid_r  <= meta_r.valid && meta_r.last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r           <= ACC_W'(prod_full);
      meta_r.row       <= meta_in.row;
      meta_r.first_col <= meta_in.first_col;
      meta_r.last_col  <= meta_in.last_col;
      meta_r.last_row  <= meta_in.last_row;
      if (meta_r.valid) begin
        acc_r <= acc_nxt;
      end
      if (meta_r.valid && meta_r.last_col) begin
        result_r.row   <= meta_r.row;
        result_r.value <= acc_nxt;
        result_r.last  <= meta_r.last_row;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

@@ sv/matrix_vector_multiply.sv @@
// Dense matrix-vector multiply over signed Q16.16 elements. Command 0 stores
// element_value at (row_index, column_index) of the matrix store, command 1
// stores it at column_index of the vector store; writes beyond the store
// size are dropped. Command 2 computes, for each row below row_count, the
// dot product over column_count columns as a Q32.32 sum that saturates at
// the signed 64-bit limits after every addition, and emits one transaction
// per row in ascending order, the final one with last_row set. Counts of
// zero act as 1, counts above the store size (or 64) are clamped. While a
// compute issues reads it holds off new input transactions. The sequencer
// issues one matrix/vector read pair per cycle, while no result transaction
// stalls, into a single multiply-accumulate lane. Each pair passes the
// store read registers, then the product register, then the accumulator
// and, on a row's last column, the result register; a stalled result
// transaction freezes the whole lane.
// Only elements written beforehand may be read; the stores are not cleared
// at reset. Write configuration only while no compute is in flight.
module matrix_vector_multiply #(
  parameter int MAX_DIM     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mvm_in_if.sink    in_ch,
  mvm_out_if.source out_ch,
  mvm_cfg_if.sink   cfg_ch
);
  import mvm_pkg::*;

  localparam int EFF_DIM = (MAX_DIM < INDEX_LIMIT) ? MAX_DIM : INDEX_LIMIT;

  logic [CNT_W-1:0]       row_count_r, column_count_r;
  logic                   in_accept, start, seq_idle, adv;
  logic                   row_ok, col_ok;
  seq_issue_t             issue;
  mem_write_t             wr;
  pipe_meta_t             meta;
  logic [VALUE_WIDTH-1:0] mat_q, vec_q;
  result_t                result;

  // Configuration registers: always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= CNT_W'(INDEX_LIMIT);
      column_count_r <= CNT_W'(INDEX_LIMIT);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROW_COUNT:    row_count_r    <= cfg_ch.data;
        REG_COLUMN_COUNT: column_count_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Take transactions only while no compute is issuing reads; this keeps
  // load writes and compute reads of the stores apart
  assign in_ch.ready = seq_idle;
  assign in_accept   = in_ch.valid && seq_idle;
  assign start       = in_accept && (in_ch.command == CMD_COMPUTE);

  assign row_ok = ({1'b0, in_ch.row_index} < CNT_W'(EFF_DIM));
  assign col_ok = ({1'b0, in_ch.column_index} < CNT_W'(EFF_DIM));

  always_comb begin
    wr.mat_we = in_accept && (in_ch.command == CMD_WRITE_MATRIX) && row_ok && col_ok;
    wr.vec_we = in_accept && (in_ch.command == CMD_WRITE_VECTOR) && col_ok;
    wr.row    = in_ch.row_index;
    wr.col    = in_ch.column_index;
    wr.data   = in_ch.element_value;
  end

  mvm_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .adv         (adv),
    .row_count   (row_count_r),
    .column_count(column_count_r),
    .idle        (seq_idle),
    .issue       (issue)
  );

  mvm_mem #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .issue(issue),
    .wr   (wr),
    .mat_q(mat_q),
    .vec_q(vec_q),
    .meta (meta)
  );

  mvm_mac #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .mat_q    (mat_q),
    .vec_q    (vec_q),
    .meta_in  (meta),
    .out_ready(out_ch.ready),
    .adv      (adv),
    .out_valid(out_ch.valid),
    .result   (result)
  );

  assign out_ch.result_row    = result.row;
  assign out_ch.product_value = result.value;
  assign out_ch.last_row      = result.last;

endmodule
